/* hdl/jkv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkv_pkg
// Shared types, codes and character constants for the key/value extractor.
// ----------------------------------------------------------------------------
package jkv_pkg;

   localparam int MAX_CHARS_DEF = 255;
   localparam int KIND_W        = 2;
   localparam int CHAR_W        = 8;
   localparam int ROLE_W        = 2;
   localparam int LEN_W         = 5;
   localparam int CSR_IDX_W     = 1;

   localparam logic [LEN_W-1:0] LEN_RESET = 5'd31;

   localparam logic [KIND_W-1:0] KIND_NEW    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PAIR   = 2'd2;

   localparam logic [ROLE_W-1:0] ROLE_KEY    = 2'd0;
   localparam logic [ROLE_W-1:0] ROLE_VALUE  = 2'd1;
   localparam logic [ROLE_W-1:0] ROLE_STATUS = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_KEY   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VALUE = 1'b1;

   localparam logic [CHAR_W-1:0] CH_APOS   = 8'h27;
   localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
   localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FIND_RD,  ST_FIND_CHK,
      ST_BACK_RD,  ST_BACK_CHK,
      ST_START_RD, ST_START_CHK,
      ST_SPACE_RD, ST_SPACE_CHK,
      ST_KCHK,
      ST_VSKIP_RD, ST_VSKIP_CHK,
      ST_VRUN_RD,  ST_VRUN_CHK,
      ST_VCHK,
      ST_KEY_RD,   ST_KEY_PUT,
      ST_VAL_RD,   ST_VAL_PUT,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic              valid;
      logic [ROLE_W-1:0] role;
      logic [CHAR_W-1:0] ch;
      logic              ok;
      logic              last;
   } emit_type;

   function automatic logic is_delim(input logic [CHAR_W-1:0] c);
      return (c == CH_APOS) || (c == CH_COMMA) || (c == CH_QUOTE) ||
             (c == CH_LF) || (c == CH_CR) || (c == CH_LBRACE) ||
             (c == CH_RBRACE) || (c == CH_COLON);
   endfunction

endpackage

/* hdl/jkv_text_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkv_text_store
// Single write, single registered read text memory.
// ----------------------------------------------------------------------------
module jkv_text_store
   import jkv_pkg::*;
#(
   parameter int DEPTH  = MAX_CHARS_DEF,
   parameter int ADDR_W = $clog2(MAX_CHARS_DEF)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CHAR_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CHAR_W-1:0] rd_data_ff
);

   logic [CHAR_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

/* hdl/jkv_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkv_seq
// Text state and scan sequencer: one pointer, one character classifier.
// ----------------------------------------------------------------------------
module jkv_seq
   import jkv_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEF,
   parameter int PTR_W     = $clog2(MAX_CHARS_DEF + 1),
   parameter int ADDR_W    = $clog2(MAX_CHARS_DEF)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [CHAR_W-1:0] req_text_byte,
   output logic              idle,
   input  logic [LEN_W-1:0]  max_key,
   input  logic [LEN_W-1:0]  max_value,
   input  logic              out_free,
   output emit_type          emit,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [CHAR_W-1:0] wr_data,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [CHAR_W-1:0] rd_data
);

   localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
   localparam logic [PTR_W-1:0] PTR_FULL = PTR_W'(MAX_CHARS);

   seq_state_type state_ff, state_in;

   logic [PTR_W-1:0] len_ff, len_in;
   logic [PTR_W-1:0] pos_ff, pos_in;
   logic             rej_ff, rej_in;
   logic             end_ff, end_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [PTR_W-1:0] loc_ff, loc_in;
   logic [PTR_W-1:0] e_ff, e_in;
   logic [PTR_W-1:0] s_ff, s_in;
   logic [PTR_W-1:0] v_ff, v_in;
   logic [PTR_W-1:0] klen_ff, klen_in;
   logic [PTR_W-1:0] vlen_ff, vlen_in;
   logic [PTR_W-1:0] cnt_ff, cnt_in;
   logic             ok_ff, ok_in;

   logic             q_delim, q_colon, q_space;
   logic             ptr_last, ptr_low, ptr_zero;
   logic [PTR_W-1:0] ptr_inc, ptr_dec;
   logic [PTR_W-1:0] klen_calc, vlen_calc;
   logic             key_bad, val_bad, pair_start;

   assign q_delim  = is_delim(rd_data);
   assign q_colon  = (rd_data == CH_COLON);
   assign q_space  = (rd_data == CH_SPACE);
   assign ptr_inc  = ptr_ff + PTR_ONE;
   assign ptr_dec  = ptr_ff - PTR_ONE;
   assign ptr_last = (ptr_inc >= len_ff);
   assign ptr_low  = (ptr_ff <= PTR_ONE);
   assign ptr_zero = (ptr_ff == '0);

   assign klen_calc = e_ff - s_ff + PTR_ONE;
   assign vlen_calc = ptr_ff - v_ff;
   assign key_bad   = (klen_calc > PTR_W'(max_key)) || (max_key == '0);
   assign val_bad   = (vlen_calc == '0) || (vlen_calc > PTR_W'(max_value)) ||
                      (max_value == '0);

   assign pair_start = req_fire && (req_kind == KIND_PAIR);
   assign idle       = (state_ff == ST_IDLE);
   assign rd_addr    = ptr_ff[ADDR_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pair_start) begin
               state_in = (rej_ff || pos_ff >= len_ff) ? ST_DONE : ST_FIND_RD;
            end
         end
         ST_FIND_RD:   state_in = ST_FIND_CHK;
         ST_FIND_CHK: begin
            if (q_colon) begin
               state_in = ptr_low ? ST_DONE : ST_BACK_RD;
            end else begin
               state_in = ptr_last ? ST_DONE : ST_FIND_RD;
            end
         end
         ST_BACK_RD:   state_in = ST_BACK_CHK;
         ST_BACK_CHK: begin
            if (q_delim) begin
               state_in = ptr_low ? ST_DONE : ST_BACK_RD;
            end else begin
               state_in = ptr_zero ? ST_SPACE_RD : ST_START_RD;
            end
         end
         ST_START_RD:  state_in = ST_START_CHK;
         ST_START_CHK: begin
            if (q_delim || ptr_zero) begin
               state_in = ST_SPACE_RD;
            end else begin
               state_in = ST_START_RD;
            end
         end
         ST_SPACE_RD:  state_in = ST_SPACE_CHK;
         ST_SPACE_CHK: state_in = ST_KCHK;
         ST_KCHK:      state_in = key_bad ? ST_DONE : ST_VSKIP_RD;
         ST_VSKIP_RD:  state_in = ST_VSKIP_CHK;
         ST_VSKIP_CHK: begin
            if (q_delim) begin
               state_in = ptr_last ? ST_DONE : ST_VSKIP_RD;
            end else begin
               state_in = ptr_last ? ST_VCHK : ST_VRUN_RD;
            end
         end
         ST_VRUN_RD:   state_in = ST_VRUN_CHK;
         ST_VRUN_CHK: begin
            if (q_delim || ptr_last) begin
               state_in = ST_VCHK;
            end else begin
               state_in = ST_VRUN_RD;
            end
         end
         ST_VCHK: begin
            if (val_bad) begin
               state_in = ST_DONE;
            end else begin
               state_in = (klen_ff == '0) ? ST_VAL_RD : ST_KEY_RD;
            end
         end
         ST_KEY_RD:    state_in = ST_KEY_PUT;
         ST_KEY_PUT: begin
            if (out_free) begin
               state_in = (cnt_ff == PTR_ONE) ? ST_VAL_RD : ST_KEY_RD;
            end
         end
         ST_VAL_RD:    state_in = ST_VAL_PUT;
         ST_VAL_PUT: begin
            if (out_free) begin
               state_in = (cnt_ff == PTR_ONE) ? ST_DONE : ST_VAL_RD;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      len_in  = len_ff;
      pos_in  = pos_ff;
      rej_in  = rej_ff;
      end_in  = end_ff;
      ptr_in  = ptr_ff;
      loc_in  = loc_ff;
      e_in    = e_ff;
      s_in    = s_ff;
      v_in    = v_ff;
      klen_in = klen_ff;
      vlen_in = vlen_ff;
      cnt_in  = cnt_ff;
      ok_in   = ok_ff;
      wr_en   = 1'b0;
      wr_addr = len_ff[ADDR_W-1:0];
      wr_data = req_text_byte;
      emit    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  KIND_NEW: begin
                     len_in = '0;
                     pos_in = '0;
                     rej_in = 1'b0;
                     end_in = 1'b0;
                  end
                  KIND_APPEND: begin
                     if (!end_ff && !rej_ff) begin
                        if (req_text_byte == CH_NUL) begin
                           end_in = 1'b1;
                        end else if (len_ff >= PTR_FULL) begin
                           rej_in = 1'b1;
                        end else begin
                           wr_en  = 1'b1;
                           len_in = len_ff + PTR_ONE;
                        end
                     end
                  end
                  KIND_PAIR: begin
                     ptr_in = pos_ff;
                     ok_in  = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_FIND_CHK: begin
            if (q_colon) begin
               loc_in = ptr_ff;
               pos_in = ptr_inc;
               ptr_in = ptr_dec;
            end else begin
               ptr_in = ptr_inc;
            end
         end
         ST_BACK_CHK: begin
            if (q_delim) begin
               ptr_in = ptr_dec;
            end else begin
               e_in = ptr_ff;
               if (!ptr_zero) begin
                  ptr_in = ptr_dec;
               end
            end
         end
         ST_START_CHK: begin
            // The pointer sits one before the candidate key start here.
            if (q_delim) begin
               ptr_in = ptr_inc;
            end else if (!ptr_zero) begin
               ptr_in = ptr_dec;
            end
         end
         ST_SPACE_CHK: begin
            s_in = q_space ? ptr_inc : ptr_ff;
         end
         ST_KCHK: begin
            klen_in = klen_calc;
            ptr_in  = loc_ff;
         end
         ST_VSKIP_CHK: begin
            ptr_in = ptr_inc;
            if (!q_delim) begin
               v_in = ptr_ff;
            end
         end
         ST_VRUN_CHK: begin
            if (!q_delim) begin
               ptr_in = ptr_inc;
            end
         end
         ST_VCHK: begin
            vlen_in = vlen_calc;
            if (!val_bad) begin
               ok_in = 1'b1;
               if (klen_ff == '0) begin
                  ptr_in = v_ff;
                  cnt_in = vlen_calc;
               end else begin
                  ptr_in = s_ff;
                  cnt_in = klen_ff;
               end
            end
         end
         ST_KEY_PUT: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.role  = ROLE_KEY;
               emit.ch    = rd_data;
               if (cnt_ff == PTR_ONE) begin
                  ptr_in = v_ff;
                  cnt_in = vlen_ff;
               end else begin
                  ptr_in = ptr_inc;
                  cnt_in = cnt_ff - PTR_ONE;
               end
            end
         end
         ST_VAL_PUT: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.role  = ROLE_VALUE;
               emit.ch    = rd_data;
               ptr_in     = ptr_inc;
               cnt_in     = cnt_ff - PTR_ONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.role  = ROLE_STATUS;
               emit.ok    = ok_ff;
               emit.last  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         pos_ff   <= '0;
         rej_ff   <= 1'b0;
         end_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         rej_ff   <= rej_in;
         end_ff   <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      loc_ff  <= loc_in;
      e_ff    <= e_in;
      s_ff    <= s_in;
      v_ff    <= v_in;
      klen_ff <= klen_in;
      vlen_ff <= vlen_in;
      cnt_ff  <= cnt_in;
      ok_ff   <= ok_in;
   end

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> out_free) else $error("word emitted with no room");

   a_pos_in_text: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= len_ff) else $error("read position beyond text");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= PTR_FULL) else $error("text length beyond store");

   a_status_ends: assert property (@(posedge clock) disable iff (reset)
      (emit.valid && emit.role == ROLE_STATUS) |=> idle)
      else $error("sequencer busy after status word");

endmodule

/* hdl/json_key_value_extractor_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_key_value_extractor_top
// Loads a text and returns key and value characters for each pair request.
// ----------------------------------------------------------------------------
//  Port group  Direction  Carries
//  req_*       in         kind and text byte, one word per command
//  rsp_*       out        role, character, ok and last, one word per result
//  csr_*       in         register index and data for the two length limits
//
//  Begin and append words are taken while the sequencer is idle, so bytes stream in every cycle.
//  A pair request holds req_ready low while the sequencer walks the store:
//  each character visited is first read from memory, then classified, and
//  the walk takes longer if rsp_ready stalls the output. All reads go through
//  the single read port of the text memory.
//  Reset clears the text state and sets both limits to 31; no clearing pass.
// ----------------------------------------------------------------------------
module json_key_value_extractor_top
   import jkv_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [CHAR_W-1:0]    req_text_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ROLE_W-1:0]    rsp_role,
   output logic [CHAR_W-1:0]    rsp_out_char,
   output logic                 rsp_ok,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]     csr_data
);

   localparam int PTR_W  = $clog2(MAX_CHARS + 1);
   localparam int ADDR_W = $clog2(MAX_CHARS);

   logic [LEN_W-1:0]  max_key_len_ff, max_val_len_ff;
   logic              rsp_valid_ff;
   logic [ROLE_W-1:0] rsp_role_ff;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_ok_ff, rsp_last_ff;
   logic              out_free, req_fire, idle;
   emit_type          emit;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CHAR_W-1:0] wr_data, rd_data;

   assign req_ready = idle;
   assign req_fire  = req_valid && idle;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_key_len_ff <= LEN_RESET;
         max_val_len_ff <= LEN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAX_KEY:   max_key_len_ff <= csr_data;
            CSR_MAX_VALUE: max_val_len_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_role_ff <= emit.role;
         rsp_char_ff <= emit.ch;
         rsp_ok_ff   <= emit.ok;
         rsp_last_ff <= emit.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_role     = rsp_role_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_last     = rsp_last_ff;

   jkv_text_store #(
      .DEPTH  (MAX_CHARS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   jkv_seq #(
      .MAX_CHARS (MAX_CHARS),
      .PTR_W     (PTR_W),
      .ADDR_W    (ADDR_W)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_fire      (req_fire),
      .req_kind      (req_kind),
      .req_text_byte (req_text_byte),
      .idle          (idle),
      .max_key       (max_key_len_ff),
      .max_value     (max_val_len_ff),
      .out_free      (out_free),
      .emit          (emit),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data)
   );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the JSON key/value extractor. Texts are streamed in
// byte by byte and pair requests are issued. A behavioural predictor works out
// the key, value and status words of every request. A checker compares each
// returned word with the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import jkv_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int ITEM_TARGET    = 360;

   typedef struct packed {
      logic [ROLE_W-1:0] role;
      logic [CHAR_W-1:0] ch;
      logic              ok;
      logic              last;
   } pair_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [KIND_W-1:0] req_kind = KIND_NEW;
   logic [CHAR_W-1:0] req_text_byte = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ROLE_W-1:0] rsp_role;
   logic [CHAR_W-1:0] rsp_out_char;
   logic rsp_ok;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MAX_KEY;
   logic [LEN_W-1:0] csr_data = '0;

   // Predictor state
   logic [CHAR_W-1:0] text_mem [0:255];
   int               text_len;
   int               read_pos;
   bit               text_rejected;
   bit               text_ended;
   logic [LEN_W-1:0] key_limit;
   logic [LEN_W-1:0] value_limit;

   pair_word_type pending_words [$];
   int  mismatches;
   int  idle_cycles;
   bit  idling_on;
   int  items_sent;

   json_key_value_extractor_top dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit is_separator(input logic [CHAR_W-1:0] c);
      return c == CH_APOS || c == CH_COMMA || c == CH_QUOTE || c == CH_LF ||
             c == CH_CR || c == CH_LBRACE || c == CH_RBRACE || c == CH_COLON;
   endfunction

   function automatic void push_word(input logic [ROLE_W-1:0] role,
                                     input logic [CHAR_W-1:0] ch,
                                     input logic ok, input logic last);
      pair_word_type w;
      w.role = role;
      w.ch   = ch;
      w.ok   = ok;
      w.last = last;
      pending_words.push_back(w);
   endfunction

   // Works out the words of one pair request and advances the read position past the colon it finds.
   function automatic void predict_pair();
      int loc, e, s, v, w, klen, vlen;
      bit found;
      found = 1'b0;
      if (!text_rejected && read_pos < text_len) begin
         loc = read_pos;
         while (loc < text_len && text_mem[loc] != CH_COLON) loc++;
         if (loc < text_len) begin
            read_pos = loc + 1;
            e = loc;
            found = 1'b1;
            while (found && is_separator(text_mem[e])) begin
               if (e <= 1) found = 1'b0;
               else e--;
            end
            if (found) begin
               s = e;
               while (s > 0 && !is_separator(text_mem[s-1])) s--;
               if (text_mem[s] == CH_SPACE) s++;
               klen = e + 1 - s;
               if (klen > key_limit || key_limit == 0) found = 1'b0;
            end
            if (found) begin
               v = loc;
               while (v < text_len && is_separator(text_mem[v])) v++;
               w = v;
               while (w < text_len && !is_separator(text_mem[w])) w++;
               vlen = w - v;
               if (vlen == 0 || vlen > value_limit || value_limit == 0) found = 1'b0;
            end
         end
      end
      if (!found) begin
         push_word(ROLE_STATUS, CH_NUL, 1'b0, 1'b1);
      end else begin
         for (int i = 0; i < klen; i++) push_word(ROLE_KEY, text_mem[s+i], 1'b0, 1'b0);
         for (int i = 0; i < vlen; i++) push_word(ROLE_VALUE, text_mem[v+i], 1'b0, 1'b0);
         push_word(ROLE_STATUS, CH_NUL, 1'b1, 1'b1);
      end
   endfunction

   function automatic void predict_item(input logic [KIND_W-1:0] kind,
                                        input logic [CHAR_W-1:0] b);
      case (kind)
         KIND_NEW: begin
            text_len = 0;
            read_pos = 0;
            text_rejected = 1'b0;
            text_ended = 1'b0;
         end
         KIND_APPEND: begin
            if (!text_ended && !text_rejected) begin
               if (b == CH_NUL) text_ended = 1'b1;
               else if (text_len >= MAX_CHARS_DEF) text_rejected = 1'b1;
               else begin
                  text_mem[text_len] = b;
                  text_len++;
               end
            end
         end
         KIND_PAIR: predict_pair();
         default: ;
      endcase
   endfunction

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idling_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Sends one command word; valid stays high across back-to-back words.
   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] b);
      int gap;
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_text_byte <= b;
      do @(posedge clock); while (!req_ready);
      predict_item(kind, b);
      items_sent++;
      gap = random_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_text(input string s, input bit terminate);
      send_word(KIND_NEW, CH_NUL);
      for (int i = 0; i < s.len(); i++) send_word(KIND_APPEND, s[i]);
      if (terminate) send_word(KIND_APPEND, CH_NUL);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CSR_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MAX_KEY) key_limit = val;
      else value_limit = val;
      csr_valid <= 1'b0;
   endtask

   task automatic test_basic_pairs();
      load_text("{\"ab\": \"xy\", \"k\":1}", 1'b1);
      repeat (3) send_word(KIND_PAIR, CH_NUL);
      send_word(KIND_APPEND, "z");            // ignored after the terminator
      send_word(KIND_UNUSED, 8'hFF);
      load_text("a:", 1'b1);                  // colon too near the start, then exhausted
      repeat (2) send_word(KIND_PAIR, CH_NUL);
      load_text("\":v", 1'b1);                // delimiter too near the start
      send_word(KIND_PAIR, CH_NUL);
      load_text(", :v", 1'b1);                // key is a lone space
      send_word(KIND_PAIR, CH_NUL);
      load_text("k:", 1'b0);                  // unterminated text
      send_word(KIND_APPEND, 8'hFF);
      send_word(KIND_PAIR, CH_NUL);
   endtask

   task automatic test_overlong_text();
      send_word(KIND_NEW, CH_NUL);
      for (int i = 0; i <= MAX_CHARS_DEF; i++)
         send_word(KIND_APPEND,
                   (i % 7 == 3) ? CH_COLON : CHAR_W'(8'h41 + (i % 26)));
      send_word(KIND_PAIR, CH_NUL);
   endtask

   task automatic test_length_limits();
      write_limit(CSR_MAX_KEY, 5'd1);
      write_limit(CSR_MAX_VALUE, 5'd1);
      load_text("a:b,ab:c,d:ef", 1'b1);
      repeat (3) send_word(KIND_PAIR, CH_NUL);
      write_limit(CSR_MAX_KEY, 5'd0);
      load_text("a:b", 1'b1);
      send_word(KIND_PAIR, CH_NUL);
      write_limit(CSR_MAX_KEY, 5'd31);
      write_limit(CSR_MAX_VALUE, 5'd0);
      load_text("a:b", 1'b1);
      send_word(KIND_PAIR, CH_NUL);
      write_limit(CSR_MAX_VALUE, 5'd31);
   endtask

   function automatic logic [CHAR_W-1:0] random_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return CHAR_W'(8'h61 + $urandom_range(0, 25));
      if (r < 88) return CH_SPACE;
      return CHAR_W'($urandom_range(1, 255));
   endfunction

   task automatic test_random_texts();
      int pairs, klen, vlen;
      do begin
         if ($urandom_range(0, 3) == 0) begin
            drain();
            write_limit(CSR_MAX_KEY, LEN_W'($urandom_range(1, 31)));
            write_limit(CSR_MAX_VALUE, LEN_W'($urandom_range(1, 31)));
            idling_on = $urandom_range(0, 2) != 0;
         end
         send_word(KIND_NEW, CH_NUL);
         pairs = $urandom_range(1, 5);
         send_word(KIND_APPEND, CH_LBRACE);
         for (int p = 0; p < pairs; p++) begin
            klen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 6);
            vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 34) : $urandom_range(1, 6);
            send_word(KIND_APPEND, CH_QUOTE);
            repeat (klen) send_word(KIND_APPEND, random_char());
            send_word(KIND_APPEND, CH_QUOTE);
            send_word(KIND_APPEND, CH_COLON);
            if ($urandom_range(0, 1)) send_word(KIND_APPEND, CH_SPACE);
            repeat (vlen) send_word(KIND_APPEND, random_char());
            send_word(KIND_APPEND, ($urandom_range(0, 3) == 0) ? CH_LF : CH_COMMA);
            if ($urandom_range(0, 7) == 0)
               send_word(KIND_W'($urandom_range(1, 3)), CHAR_W'($urandom_range(0, 255)));
         end
         send_word(KIND_APPEND, CH_RBRACE);
         if ($urandom_range(0, 4) != 0) send_word(KIND_APPEND, CH_NUL);
         repeat (pairs + $urandom_range(0, 2)) send_word(KIND_PAIR, CH_NUL);
      end while (items_sent < ITEM_TARGET);
   endtask

   // Result side back-pressure
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pair_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word role=%0d char=%h", rsp_role, rsp_out_char);
         end else begin
            exp_w = pending_words.pop_front();
            if (rsp_role !== exp_w.role || rsp_out_char !== exp_w.ch ||
                rsp_ok !== exp_w.ok || rsp_last !== exp_w.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected role=%0d char=%h ok=%b last=%b, got %0d %h %b %b",
                           exp_w.role, exp_w.ch, exp_w.ok, exp_w.last,
                           rsp_role, rsp_out_char, rsp_ok, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      text_len = 0;
      read_pos = 0;
      text_rejected = 1'b0;
      text_ended = 1'b0;
      key_limit = LEN_RESET;
      value_limit = LEN_RESET;
      mismatches = 0;
      idle_cycles = 0;
      items_sent = 0;
      idling_on = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_pairs();
      test_overlong_text();
      test_length_limits();
      test_random_texts();
      drain();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
